### rtl/ele_pkg.sv
// Shared types and constants for the echoing line editor.
`timescale 1ns / 1ps
package ele_pkg;

  localparam int LINE_CAPACITY = 64;
  localparam int CODE_W        = 9;
  localparam int KIND_W        = 3;
  localparam int BYTE_W        = 8;
  localparam int MAX_LINE_W    = 7;
  localparam logic [MAX_LINE_W-1:0] MAX_LINE_RST = 7'd64;

  localparam logic [CODE_W-1:0] KEY_EOT   = 9'd4;
  localparam logic [CODE_W-1:0] KEY_BS    = 9'd8;
  localparam logic [CODE_W-1:0] KEY_LF    = 9'd10;
  localparam logic [CODE_W-1:0] KEY_CR    = 9'd13;
  localparam logic [CODE_W-1:0] KEY_NAK   = 9'd21;
  localparam logic [CODE_W-1:0] KEY_SPACE = 9'd32;
  localparam logic [CODE_W-1:0] KEY_TILDE = 9'd126;
  localparam logic [CODE_W-1:0] KEY_DEL   = 9'd127;

  localparam logic [BYTE_W-1:0] BYTE_NL = 8'd10;

  typedef enum logic [KIND_W-1:0] {
    KIND_ECHO  = 3'd0,
    KIND_ERASE = 3'd1,
    KIND_LINE  = 3'd2,
    KIND_EMPTY = 3'd3,
    KIND_EOI   = 3'd4
  } kind_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ERASE,
    ST_EMPTY,
    ST_STREAM
  } state_t;

  typedef struct packed {
    logic we;
    logic re;
  } mem_ctl_t;

endpackage

### rtl/ele_if.sv
// Handshake channel interfaces for input, result and configuration words.
`timescale 1ns / 1ps
interface ele_in_if;
  logic                       valid;
  logic                       ready;
  logic [ele_pkg::CODE_W-1:0] code;
  logic                       end_of_input;
  modport source (output valid, code, end_of_input, input ready);
  modport sink (input valid, code, end_of_input, output ready);
endinterface

interface ele_out_if;
  logic                       valid;
  logic                       ready;
  logic [ele_pkg::KIND_W-1:0] kind;
  logic [ele_pkg::BYTE_W-1:0] data;
  logic                       last;
  modport source (output valid, kind, data, last, input ready);
  modport sink (input valid, kind, data, last, output ready);
endinterface

interface ele_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [ele_pkg::MAX_LINE_W-1:0] data;
  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

### rtl/ele_line_mem.sv
// Line byte store: one write port, one registered read port with enable.
`timescale 1ns / 1ps
module ele_line_mem #(
  parameter int LINE_CAPACITY = ele_pkg::LINE_CAPACITY,
  localparam int AW = $clog2(LINE_CAPACITY)
) (
  input  logic                       clk,
  input  ele_pkg::mem_ctl_t          ctl,
  input  logic [AW-1:0]              waddr,
  input  logic [ele_pkg::BYTE_W-1:0] wdata,
  input  logic [AW-1:0]              raddr,
  output logic [ele_pkg::BYTE_W-1:0] rdata
);

  logic [ele_pkg::BYTE_W-1:0] mem [LINE_CAPACITY];
  logic [ele_pkg::BYTE_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (ctl.we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

### rtl/ele_ctrl.sv
// Key decoder, line length tracking, result sequencer and output register.
`timescale 1ns / 1ps
module ele_ctrl #(
  parameter int LINE_CAPACITY = ele_pkg::LINE_CAPACITY,
  localparam int AW = $clog2(LINE_CAPACITY),
  localparam int LW = $clog2(LINE_CAPACITY + 1)
) (
  input  logic                           clk,
  input  logic                           rst_n,
  ele_in_if.sink                         in_ch,
  ele_out_if.source                      out_ch,
  input  logic [ele_pkg::MAX_LINE_W-1:0] max_line,
  output ele_pkg::mem_ctl_t              mem_ctl,
  output logic [AW-1:0]                  mem_waddr,
  output logic [ele_pkg::BYTE_W-1:0]     mem_wdata,
  output logic [AW-1:0]                  mem_raddr,
  input  logic [ele_pkg::BYTE_W-1:0]     mem_rdata
);

  localparam logic [ele_pkg::MAX_LINE_W-1:0] CAP_M = ele_pkg::MAX_LINE_W'(LINE_CAPACITY);

  ele_pkg::state_t            state_r, state_nxt;
  logic [LW-1:0]              len_r, len_nxt;
  logic [AW-1:0]              idx_r, idx_nxt;
  logic                       ov_r, ov_nxt;
  ele_pkg::kind_t             okind_r, okind_nxt;
  logic [ele_pkg::BYTE_W-1:0] odata_r, odata_nxt;
  logic                       olast_r, olast_nxt;

  logic                           out_free;
  logic                           acc;
  logic [ele_pkg::MAX_LINE_W-1:0] size;
  logic                           room;
  logic                           empty;
  logic                           printable;
  logic                           stream_last;

  always_comb begin
    if (max_line == '0) begin
      size = ele_pkg::MAX_LINE_W'(1);
    end else if (max_line > CAP_M) begin
      size = CAP_M;
    end else begin
      size = max_line;
    end
  end

  assign out_free    = !ov_r || out_ch.ready;
  assign in_ch.ready = (state_r == ele_pkg::ST_IDLE) && out_free;
  assign acc         = in_ch.valid && in_ch.ready;
  assign empty       = (len_r == '0);
  assign room        = ele_pkg::MAX_LINE_W'(len_r) < (size - ele_pkg::MAX_LINE_W'(1));
  assign printable   = (in_ch.code >= ele_pkg::KEY_SPACE) && (in_ch.code <= ele_pkg::KEY_TILDE);
  assign stream_last = (LW'(idx_r) == (len_r - LW'(1)));

  assign mem_waddr = len_r[AW-1:0];
  assign mem_wdata = in_ch.code[ele_pkg::BYTE_W-1:0];

  always_comb begin
    state_nxt   = state_r;
    len_nxt     = len_r;
    idx_nxt     = idx_r;
    ov_nxt      = ov_r && !out_ch.ready;
    okind_nxt   = okind_r;
    odata_nxt   = odata_r;
    olast_nxt   = olast_r;
    mem_ctl     = '0;
    mem_raddr   = '0;

    unique case (state_r)
      ele_pkg::ST_IDLE: begin
        if (acc) begin
          idx_nxt = '0;
          priority if (in_ch.end_of_input) begin
            if (empty) begin
              ov_nxt    = 1'b1;
              okind_nxt = ele_pkg::KIND_EOI;
              odata_nxt = '0;
              olast_nxt = 1'b1;
            end else begin
              mem_ctl.re = 1'b1;
              state_nxt  = ele_pkg::ST_STREAM;
            end
          end else if (in_ch.code == ele_pkg::KEY_LF || in_ch.code == ele_pkg::KEY_CR) begin
            ov_nxt    = 1'b1;
            okind_nxt = ele_pkg::KIND_ECHO;
            odata_nxt = ele_pkg::BYTE_NL;
            olast_nxt = 1'b0;
            if (empty) begin
              state_nxt = ele_pkg::ST_EMPTY;
            end else begin
              mem_ctl.re = 1'b1;
              state_nxt  = ele_pkg::ST_STREAM;
            end
          end else if (in_ch.code == ele_pkg::KEY_EOT) begin
            if (empty) begin
              ov_nxt    = 1'b1;
              okind_nxt = ele_pkg::KIND_EOI;
              odata_nxt = '0;
              olast_nxt = 1'b1;
            end
          end else if (in_ch.code == ele_pkg::KEY_BS || in_ch.code == ele_pkg::KEY_DEL) begin
            if (!empty) begin
              len_nxt   = len_r - LW'(1);
              ov_nxt    = 1'b1;
              okind_nxt = ele_pkg::KIND_ERASE;
              odata_nxt = '0;
              olast_nxt = 1'b1;
            end
          end else if (in_ch.code == ele_pkg::KEY_NAK) begin
            if (!empty) begin
              state_nxt = ele_pkg::ST_ERASE;
            end
          end else if (printable && room) begin
            mem_ctl.we = 1'b1;
            len_nxt    = len_r + LW'(1);
            ov_nxt     = 1'b1;
            okind_nxt  = ele_pkg::KIND_ECHO;
            odata_nxt  = in_ch.code[ele_pkg::BYTE_W-1:0];
            olast_nxt  = 1'b1;
          end
        end
      end
      ele_pkg::ST_ERASE: begin
        if (out_free) begin
          len_nxt   = len_r - LW'(1);
          ov_nxt    = 1'b1;
          okind_nxt = ele_pkg::KIND_ERASE;
          odata_nxt = '0;
          olast_nxt = (len_r == LW'(1));
          if (len_r == LW'(1)) begin
            state_nxt = ele_pkg::ST_IDLE;
          end
        end
      end
      ele_pkg::ST_EMPTY: begin
        if (out_free) begin
          ov_nxt    = 1'b1;
          okind_nxt = ele_pkg::KIND_EMPTY;
          odata_nxt = '0;
          olast_nxt = 1'b1;
          state_nxt = ele_pkg::ST_IDLE;
        end
      end
      ele_pkg::ST_STREAM: begin
        if (out_free) begin
          ov_nxt    = 1'b1;
          okind_nxt = ele_pkg::KIND_LINE;
          odata_nxt = mem_rdata;
          olast_nxt = stream_last;
          if (stream_last) begin
            len_nxt   = '0;
            state_nxt = ele_pkg::ST_IDLE;
          end else begin
            idx_nxt    = idx_r + AW'(1);
            mem_ctl.re = 1'b1;
            mem_raddr  = idx_r + AW'(1);
          end
        end
      end
      default: begin
        state_nxt = ele_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ele_pkg::ST_IDLE;
      len_r   <= '0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      len_r   <= len_nxt;
      ov_r    <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r   <= idx_nxt;
    okind_r <= okind_nxt;
    odata_r <= odata_nxt;
    olast_r <= olast_nxt;
  end

  assign out_ch.valid = ov_r;
  assign out_ch.kind  = okind_r;
  assign out_ch.data  = odata_r;
  assign out_ch.last  = olast_r;

endmodule

### rtl/echoing_line_editor.sv
// Top level of the echoing line editor: size register, sequencer and line store.
// An item that causes one result shows it on the output register in the cycle after acceptance.
// A line streams out one byte per cycle while the output is taken; the first store read is issued at acceptance.
// The next item is accepted once the last result is taken, or in the cycle it is taken.
// rst_n clears the line length and sets max_line to 64; the store itself is not cleared.
`timescale 1ns / 1ps
module echoing_line_editor #(
  parameter int LINE_CAPACITY = ele_pkg::LINE_CAPACITY
) (
  input  logic       clk,
  input  logic       rst_n,
  ele_in_if.sink     in_ch,
  ele_out_if.source  out_ch,
  ele_cfg_if.sink    cfg_ch
);

  localparam int AW = $clog2(LINE_CAPACITY);

  logic [ele_pkg::MAX_LINE_W-1:0] max_line_r;
  ele_pkg::mem_ctl_t              mem_ctl;
  logic [AW-1:0]                  mem_waddr;
  logic [AW-1:0]                  mem_raddr;
  logic [ele_pkg::BYTE_W-1:0]     mem_wdata;
  logic [ele_pkg::BYTE_W-1:0]     mem_rdata;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_line_r <= ele_pkg::MAX_LINE_RST;
    end else if (cfg_ch.valid) begin
      max_line_r <= cfg_ch.data;
    end
  end

  ele_ctrl #(
    .LINE_CAPACITY(LINE_CAPACITY)
  ) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .out_ch   (out_ch),
    .max_line (max_line_r),
    .mem_ctl  (mem_ctl),
    .mem_waddr(mem_waddr),
    .mem_wdata(mem_wdata),
    .mem_raddr(mem_raddr),
    .mem_rdata(mem_rdata)
  );

  ele_line_mem #(
    .LINE_CAPACITY(LINE_CAPACITY)
  ) u_mem (
    .clk  (clk),
    .ctl  (mem_ctl),
    .waddr(mem_waddr),
    .wdata(mem_wdata),
    .raddr(mem_raddr),
    .rdata(mem_rdata)
  );

endmodule

### tb/sv/echoing_line_editor_tb.sv
// Self-checking testbench for the echoing line editor: key words in, echo and line words out.
`timescale 1ns / 1ps
module echoing_line_editor_tb;

  localparam int QUIET_LIMIT = 2000;
  localparam int LONG_HOLD   = 300;

  typedef struct {
    ele_pkg::kind_t             kind;
    logic [ele_pkg::BYTE_W-1:0] data;
    logic                       last;
  } editor_word_t;

  class line_result_tracker;
    logic [ele_pkg::BYTE_W-1:0]     typed_bytes [ele_pkg::LINE_CAPACITY];
    int                             typed_len;
    logic [ele_pkg::MAX_LINE_W-1:0] size_reg;
    editor_word_t                   awaited_words [$];
    int                             errors;

    function new();
      typed_len = 0;
      size_reg  = ele_pkg::MAX_LINE_RST;
      errors    = 0;
    endfunction

    function void emit(ele_pkg::kind_t k, logic [ele_pkg::BYTE_W-1:0] d);
      editor_word_t w;
      w.kind = k;
      w.data = d;
      w.last = 1'b0;
      awaited_words.push_back(w);
    endfunction

    function void stream_line();
      for (int i = 0; i < typed_len; i++) emit(ele_pkg::KIND_LINE, typed_bytes[i]);
      typed_len = 0;
    endfunction

    function int take_key(logic [ele_pkg::CODE_W-1:0] code, logic eoi);
      int prior_cnt;
      int room_limit;
      int n;
      prior_cnt  = awaited_words.size();
      room_limit = (size_reg < 1) ? 1 :
                   (size_reg > ele_pkg::LINE_CAPACITY) ? ele_pkg::LINE_CAPACITY :
                   int'(size_reg);
      if (eoi) begin
        if (typed_len == 0) emit(ele_pkg::KIND_EOI, '0);
        else stream_line();
      end else if (code == ele_pkg::KEY_LF || code == ele_pkg::KEY_CR) begin
        emit(ele_pkg::KIND_ECHO, ele_pkg::BYTE_NL);
        if (typed_len == 0) emit(ele_pkg::KIND_EMPTY, '0);
        else stream_line();
      end else if (code == ele_pkg::KEY_EOT) begin
        if (typed_len == 0) emit(ele_pkg::KIND_EOI, '0);
      end else if (code == ele_pkg::KEY_BS || code == ele_pkg::KEY_DEL) begin
        if (typed_len > 0) begin
          typed_len--;
          emit(ele_pkg::KIND_ERASE, '0);
        end
      end else if (code == ele_pkg::KEY_NAK) begin
        while (typed_len > 0) begin
          typed_len--;
          emit(ele_pkg::KIND_ERASE, '0);
        end
      end else if (code >= ele_pkg::KEY_SPACE && code <= ele_pkg::KEY_TILDE) begin
        if (typed_len < room_limit - 1) begin
          typed_bytes[typed_len] = code[ele_pkg::BYTE_W-1:0];
          typed_len++;
          emit(ele_pkg::KIND_ECHO, code[ele_pkg::BYTE_W-1:0]);
        end
      end
      n = awaited_words.size() - prior_cnt;
      if (n > 0) awaited_words[awaited_words.size()-1].last = 1'b1;
      return n;
    endfunction

    function void match_word(logic [ele_pkg::KIND_W-1:0] kind,
                             logic [ele_pkg::BYTE_W-1:0] data, logic last);
      editor_word_t w;
      if (awaited_words.size() == 0) begin
        $error("unexpected result word: kind %0d data %0d last %0d", kind, data, last);
        errors++;
        return;
      end
      w = awaited_words.pop_front();
      if (kind !== w.kind) begin
        $error("kind mismatch: expected %0d, got %0d", w.kind, kind);
        errors++;
      end
      if (data !== w.data) begin
        $error("data mismatch: expected %0d, got %0d", w.data, data);
        errors++;
      end
      if (last !== w.last) begin
        $error("last mismatch: expected %0d, got %0d", w.last, last);
        errors++;
      end
    endfunction

    function int pending();
      return awaited_words.size();
    endfunction

    function void close_out();
      if (awaited_words.size() != 0) begin
        $error("%0d expected result words never arrived", awaited_words.size());
        errors += awaited_words.size();
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;

  ele_in_if  in_ch ();
  ele_out_if out_ch ();
  ele_cfg_if cfg_ch ();

  echoing_line_editor DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  line_result_tracker tracker;
  int send_gap_pct   = 0;
  int recv_stall_pct = 0;
  bit hold_req       = 1'b0;
  int keys_sent      = 0;
  int keys_counted   = 0;
  int words_seen     = 0;
  int quiet_cycles   = 0;

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  initial begin
    int hold_left;
    hold_left = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_ch.valid && out_ch.ready) begin
        tracker.match_word(out_ch.kind, out_ch.data, out_ch.last);
        words_seen++;
      end
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_key(input logic [ele_pkg::CODE_W-1:0] code, input logic eoi);
    while (send_gap_pct > 0 && $urandom_range(99) < send_gap_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid        <= 1'b1;
    in_ch.code         <= code;
    in_ch.end_of_input <= eoi;
    do @(posedge clk); while (!in_ch.ready);
    keys_sent++;
    if (tracker.take_key(code, eoi) > 0) keys_counted++;
  endtask

  // drop valid, wait for every awaited word, then settle
  task automatic wait_drain(input int settle);
    in_ch.valid <= 1'b0;
    while (tracker.pending() != 0) @(posedge clk);
    repeat (settle) @(posedge clk);
  endtask

  task automatic set_line_size(input logic [ele_pkg::MAX_LINE_W-1:0] v);
    cfg_ch.valid <= 1'b1;
    cfg_ch.data  <= v;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    tracker.size_reg = v;
  endtask

  task automatic type_line();
    int n;
    int roll;
    n = ($urandom_range(7) == 0) ? $urandom_range(40, 70) : $urandom_range(0, 12);
    repeat (n) begin
      roll = $urandom_range(99);
      if (roll < 6)
        send_key(($urandom_range(1) != 0) ? ele_pkg::KEY_BS : ele_pkg::KEY_DEL, 1'b0);
      else if (roll < 8)
        send_key(ele_pkg::KEY_NAK, 1'b0);
      else if (roll < 14)
        send_key(ele_pkg::CODE_W'($urandom_range(511)), ($urandom_range(9) == 0));
      else
        send_key(ele_pkg::CODE_W'($urandom_range(ele_pkg::KEY_SPACE, ele_pkg::KEY_TILDE)),
                 1'b0);
    end
    roll = $urandom_range(99);
    if (roll < 65)
      send_key(($urandom_range(1) != 0) ? ele_pkg::KEY_LF : ele_pkg::KEY_CR, 1'b0);
    else if (roll < 85)
      send_key(ele_pkg::CODE_W'($urandom_range(511)), 1'b1);
    else if (roll < 92)
      send_key(ele_pkg::KEY_EOT, 1'b0);
  endtask

  task automatic run_phase(input int gap, input int stall,
                           input logic [ele_pkg::MAX_LINE_W-1:0] sz,
                           input bit long_hold, input int target);
    int start_cnt;
    bit paused;
    wait_drain(8);
    set_line_size(sz);
    send_gap_pct   = gap;
    recv_stall_pct = stall;
    start_cnt      = keys_sent;
    paused         = 1'b0;
    if (long_hold) hold_req = 1'b1;
    while (keys_sent - start_cnt < target) begin
      type_line();
      if (!paused && keys_sent - start_cnt >= target / 2) begin
        paused = 1'b1;
        wait_drain(1);
      end
    end
  endtask

  initial begin
    tracker = new();
    rst_n              <= 1'b0;
    in_ch.valid        <= 1'b0;
    in_ch.code         <= '0;
    in_ch.end_of_input <= 1'b0;
    cfg_ch.valid       <= 1'b0;
    cfg_ch.data        <= ele_pkg::MAX_LINE_RST;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_key(9'd65, 1'b0);
    send_key(ele_pkg::KEY_SPACE, 1'b0);
    send_key(ele_pkg::KEY_TILDE, 1'b0);
    send_key(ele_pkg::KEY_BS, 1'b0);
    send_key(ele_pkg::KEY_DEL, 1'b0);
    send_key(ele_pkg::KEY_NAK, 1'b0);
    send_key(ele_pkg::KEY_BS, 1'b0);
    send_key(ele_pkg::KEY_NAK, 1'b0);
    send_key(ele_pkg::KEY_EOT, 1'b0);
    send_key(ele_pkg::KEY_CR, 1'b0);
    send_key(9'd120, 1'b0);
    send_key(ele_pkg::KEY_EOT, 1'b0);
    send_key(9'd31, 1'b0);
    send_key(9'd128, 1'b0);
    send_key(9'd511, 1'b0);
    send_key(ele_pkg::KEY_LF, 1'b0);
    send_key(9'd121, 1'b0);
    send_key(9'd0, 1'b1);
    send_key(9'd511, 1'b1);

    wait_drain(8);
    set_line_size(7'd1);
    send_key(9'd122, 1'b0);
    send_key(ele_pkg::KEY_CR, 1'b0);

    wait_drain(8);
    set_line_size(7'd4);
    send_key(9'd97, 1'b0);
    send_key(9'd98, 1'b0);
    send_key(9'd99, 1'b0);
    send_key(9'd100, 1'b0);
    // shrink the line size while three bytes are held
    wait_drain(8);
    set_line_size(7'd2);
    send_key(9'd101, 1'b0);
    send_key(ele_pkg::KEY_BS, 1'b0);
    send_key(9'd300, 1'b1);

    run_phase(0, 0, 7'd64, 1'b0, 32);
    run_phase(49, 0, 7'd9, 1'b0, 32);
    run_phase(0, 49, 7'd64, 1'b1, 32);
    run_phase(17, 17, 7'd33, 1'b0, 32);

    wait_drain(70);
    tracker.close_out();
    $display("Sent %0d key words (%0d with results), checked %0d result words",
             keys_sent, keys_counted, words_seen);
    $display("Line sizes 1, 2, 4, 9, 33 and 64 under four handshake mixes and a long stall");
    if (tracker.errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
